// File: hw/rtl/arlpp_pkg.sv
// Shared types, constants and saturation helper for the rate-limited path planner.
// No dependencies; every other file of the block but arlpp_div imports this package.
`default_nettype none

package arlpp_pkg;

    // Shared multiplier operand and product widths
    localparam int OP_W   = 33;
    localparam int PROD_W = 2 * OP_W;

    typedef logic signed [OP_W-1:0]   mul_op_t;
    typedef logic signed [PROD_W-1:0] mul_prod_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_GAIN_HIGH      = 3'd0;
    localparam logic [2:0] CFG_GAIN_LOW       = 3'd1;
    localparam logic [2:0] CFG_DECAY_RATE     = 3'd2;
    localparam logic [2:0] CFG_SYNC_RATIO     = 3'd3;
    localparam logic [2:0] CFG_VEL_LIMIT      = 3'd4;
    localparam logic [2:0] CFG_VEL_STEP_LIMIT = 3'd5;
    localparam logic [2:0] CFG_SAMPLE_TIME    = 3'd6;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL_X,
        ST_DIV_START,
        ST_DIV,
        ST_MUL_GAIN,
        ST_GAIN,
        ST_MUL_VEL,
        ST_MUL_T,
        ST_MUL_CORR,
        ST_CORR,
        ST_BOUND,
        ST_CLAMP,
        ST_MUL_POS,
        ST_POS,
        ST_DONE
    } state_t;

    localparam mul_prod_t SAT_MAX = {{(PROD_W-31){1'b0}}, {31{1'b1}}};
    localparam mul_prod_t SAT_MIN = {{(PROD_W-31){1'b1}}, {31{1'b0}}};

    // Saturate a wide signed value to the 32-bit signed range
    function automatic logic signed [31:0] sat32(input mul_prod_t v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/adaptive_rate_limited_path_planner.sv
// Adaptive rate-limited path planner: takes one word of requested position, feedback
// position and sync delay, and returns the next planned position and the clamped
// velocity, all with FRACTION_BITS fraction bits. Each word runs through the iterative
// divider of the gain schedule (one quotient bit per cycle) and makes six passes through
// the one shared multiplier. s_tready is high only between words; a finished result
// may wait in the output register while the next word is accepted and worked on.
// Depends on arlpp_pkg, arlpp_mul and arlpp_div.
`default_nettype none

module adaptive_rate_limited_path_planner #(
    parameter int FRACTION_BITS = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Input words
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [95:0] s_tdata,   // requested_position, actuator_feedback, sync_delay, pad
    // Result words
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata,   // smoothed_position, commanded_velocity
    // Configuration writes
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [31:0] cfg_data
);
    import arlpp_pkg::*;

    localparam logic [31:0] ONE = 32'(1) << FRACTION_BITS;

    // Configuration registers
    logic [23:0] gain_high_reg, gain_low_reg, decay_rate_reg, sync_ratio_reg;
    logic [30:0] vel_limit_reg, vel_step_limit_reg;
    logic [15:0] sample_time_reg;

    // Sequencer and state
    state_t             state_reg, state_next;
    logic signed [31:0] last_pos_reg, last_vel_reg;
    logic               m_tvalid_reg;
    logic [63:0]        m_tdata_reg;

    // Working registers
    logic signed [31:0]     req_reg, fdb_reg, err_reg, vel_reg, hi_reg, lo_reg, pos_reg;
    logic [30:0]            delay_reg, t_reg;
    logic signed [24:0]     gain_reg;
    logic [FRACTION_BITS:0] f_reg;

    // Shared units
    mul_op_t                mul_a, mul_b;
    mul_prod_t              prod, prod_sh;
    logic                   div_start, div_done;
    logic [31:0]            div_den;
    logic [FRACTION_BITS:0] div_q;
    logic                   out_load;

    // Helper values
    logic signed [32:0] err_wide;
    logic [31:0]        aerr;
    logic signed [31:0] prod_sat;
    logic signed [24:0] gain_diff;
    logic signed [33:0] vel_adj;
    logic signed [32:0] hi_wide, lo_wide;
    logic signed [31:0] vel_clamp;

    arlpp_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    arlpp_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_q)
    );

    // Product scaled back to the Q format, with floor rounding
    assign prod_sh  = prod >>> FRACTION_BITS;
    assign prod_sat = sat32(prod_sh);

    assign err_wide  = 33'(req_reg) - 33'(fdb_reg);
    assign aerr      = err_reg[31] ? 32'(-33'(err_reg)) : 32'(err_reg);
    assign gain_diff = $signed({1'b0, gain_low_reg}) - $signed({1'b0, gain_high_reg});
    assign div_den   = ONE + {1'b0, prod_sat[30:0]};

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_ERR;
            ST_ERR:       state_next = ST_MUL_X;
            ST_MUL_X:     state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV;
            ST_DIV:       if (div_done) state_next = ST_MUL_GAIN;
            ST_MUL_GAIN:  state_next = ST_GAIN;
            ST_GAIN:      state_next = ST_MUL_T;
            ST_MUL_T:     state_next = ST_MUL_VEL;
            ST_MUL_VEL:   state_next = ST_MUL_CORR;
            ST_MUL_CORR:  state_next = ST_CORR;
            ST_CORR:      state_next = ST_BOUND;
            ST_BOUND:     state_next = ST_CLAMP;
            ST_CLAMP:     state_next = ST_MUL_POS;
            ST_MUL_POS:   state_next = ST_POS;
            ST_POS:       state_next = ST_DONE;
            ST_DONE:      if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, divider start, output load and multiplier operands
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            ST_IDLE:      s_tready = 1'b1;
            ST_MUL_X: begin
                mul_a = mul_op_t'({1'b0, decay_rate_reg});
                mul_b = mul_op_t'({1'b0, aerr});
            end
            ST_DIV_START: div_start = 1'b1;
            ST_MUL_GAIN: begin
                mul_a = mul_op_t'(gain_diff);
                mul_b = mul_op_t'({1'b0, f_reg});
            end
            ST_MUL_T: begin
                mul_a = mul_op_t'({1'b0, sync_ratio_reg});
                mul_b = mul_op_t'(gain_reg);
            end
            ST_MUL_VEL: begin
                mul_a = mul_op_t'(err_reg);
                mul_b = mul_op_t'(gain_reg);
            end
            ST_MUL_CORR: begin
                mul_a = mul_op_t'({1'b0, t_reg});
                mul_b = mul_op_t'({1'b0, delay_reg});
            end
            ST_MUL_POS: begin
                mul_a = mul_op_t'({1'b0, sample_time_reg});
                mul_b = mul_op_t'(vel_reg);
            end
            ST_DONE:      out_load = !m_tvalid_reg || m_tready;
            default: begin
            end
        endcase
    end

    // Sign correction by the sync term, toward zero unless it overshoots
    always_comb begin
        if (vel_reg > 32'sd0) begin
            vel_adj = 34'(vel_reg) - 34'(prod_sat);
        end else if (vel_reg < 32'sd0) begin
            vel_adj = 34'(vel_reg) + 34'(prod_sat);
        end else begin
            vel_adj = 34'(vel_reg);
        end
    end

    // Rate and magnitude bounds
    always_comb begin
        hi_wide = 33'(last_vel_reg) + $signed({2'b0, vel_step_limit_reg});
        if (hi_wide > $signed({2'b0, vel_limit_reg})) begin
            hi_wide = $signed({2'b0, vel_limit_reg});
        end
        lo_wide = 33'(last_vel_reg) - $signed({2'b0, vel_step_limit_reg});
        if (lo_wide < -$signed({2'b0, vel_limit_reg})) begin
            lo_wide = -$signed({2'b0, vel_limit_reg});
        end
    end

    // Clamp; the upper bound wins when the bounds cross
    always_comb begin
        vel_clamp = vel_reg;
        if (vel_clamp < lo_reg) begin
            vel_clamp = lo_reg;
        end
        if (vel_clamp > hi_reg) begin
            vel_clamp = hi_reg;
        end
    end

    // Datapath registers advanced by the sequencer
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                req_reg   <= s_tdata[31:0];
                fdb_reg   <= s_tdata[63:32];
                delay_reg <= s_tdata[94:64];
            end
            ST_ERR:   err_reg  <= sat32(PROD_W'(err_wide));
            ST_DIV:   f_reg    <= div_q;
            ST_GAIN:  gain_reg <= $signed({1'b0, gain_high_reg}) + prod_sh[24:0];
            ST_MUL_VEL:  t_reg   <= prod_sat[30:0];
            ST_MUL_CORR: vel_reg <= prod_sat;
            ST_CORR:  vel_reg  <= sat32(PROD_W'(vel_adj));
            ST_BOUND: begin
                hi_reg <= hi_wide[31:0];
                lo_reg <= lo_wide[31:0];
            end
            ST_CLAMP: vel_reg  <= vel_clamp;
            ST_POS:   pos_reg  <= sat32(PROD_W'(last_pos_reg) + prod_sh);
            default: begin
            end
        endcase
        if (out_load) begin
            m_tdata_reg <= {vel_reg, pos_reg};
        end
    end

    // Control state, planner state and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            m_tvalid_reg       <= 1'b0;
            last_pos_reg       <= '0;
            last_vel_reg       <= '0;
            gain_high_reg      <= 24'd2116623;
            gain_low_reg       <= 24'd211662;
            decay_rate_reg     <= 24'd819200;
            sync_ratio_reg     <= 24'd65536;
            vel_limit_reg      <= 31'd10202133;
            vel_step_limit_reg <= 31'd2116616;
            sample_time_reg    <= 16'd655;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
                last_pos_reg <= pos_reg;
                last_vel_reg <= vel_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_GAIN_HIGH:      gain_high_reg      <= cfg_data[23:0];
                    CFG_GAIN_LOW:       gain_low_reg       <= cfg_data[23:0];
                    CFG_DECAY_RATE:     decay_rate_reg     <= cfg_data[23:0];
                    CFG_SYNC_RATIO:     sync_ratio_reg     <= cfg_data[23:0];
                    CFG_VEL_LIMIT:      vel_limit_reg      <= cfg_data[30:0];
                    CFG_VEL_STEP_LIMIT: vel_step_limit_reg <= cfg_data[30:0];
                    CFG_SAMPLE_TIME:    sample_time_reg    <= cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

`ifndef NO_ASSERTIONS
    // The block holds off new words once one is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a word is in progress");

    // Divider completion only lands while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider done outside the divide step");

    // The schedule factor never exceeds one
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> {{(31 - FRACTION_BITS){1'b0}}, div_q} <= ONE)
        else $error("schedule factor above one");

    // The clamped velocity stays at or below the magnitude limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL_POS |-> vel_reg <= $signed({1'b0, vel_limit_reg}))
        else $error("clamped velocity above limit");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/arlpp_mul.sv
// Shared signed multiplier of the path planner, product registered.
// Depends on arlpp_pkg for operand and product types.
`default_nettype none

module arlpp_mul (
    input  wire                  aclk,
    input  arlpp_pkg::mul_op_t   op_a,
    input  arlpp_pkg::mul_op_t   op_b,
    output arlpp_pkg::mul_prod_t prod
);
    import arlpp_pkg::*;

    mul_prod_t prod_reg;
    mul_prod_t prod_next;

    // Form the full-width signed product
    always_comb begin
        prod_next = mul_prod_t'(op_a) * mul_prod_t'(op_b);
    end

    // Register the product for the next sequencer step
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: hw/rtl/arlpp_div.sv
// Iterative restoring divider: 2^(2F) / den, one quotient bit per cycle.
// Standalone; the planner top starts it once per word for the gain schedule factor.
`default_nettype none

module arlpp_div #(
    parameter int FRACTION_BITS = 16
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     start,
    input  wire  [31:0]             den,
    output logic                    done,
    output logic [FRACTION_BITS:0]  quot
);

    localparam int NUM_MSB = 2 * FRACTION_BITS;
    localparam int CNT_W   = $clog2(NUM_MSB + 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [31:0]            rem_reg, rem_next;
    logic [31:0]            den_reg, den_next;
    logic [FRACTION_BITS:0] quot_reg, quot_next;

    logic [32:0] trial;

    // Load on start; then one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        trial     = {rem_reg, (cnt_reg == CNT_W'(NUM_MSB))};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_MSB);
            rem_next  = '0;
            den_next  = den;
            quot_next = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next  = 32'(trial - {1'b0, den_reg});
                quot_next = {quot_reg[FRACTION_BITS-1:0], 1'b1};
            end else begin
                rem_next  = trial[31:0];
                quot_next = {quot_reg[FRACTION_BITS-1:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    // Control state clears on reset; working registers hold payload only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// File: tb/planner_checker.sv
`timescale 1ns / 1ps
// Checker for the rate-limited path planner: watches the input, result and
// configuration channels, predicts every result word and compares it on arrival.
// Depends on arlpp_pkg for the configuration register indexes.

module planner_checker (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [95:0] s_tdata,    // requested_position, actuator_feedback, sync_delay, pad
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [63:0] m_tdata,    // smoothed_position, commanded_velocity
    input  wire         cfg_valid,
    input  wire         cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [31:0] cfg_data,
    output int          mismatches,
    output int          outstanding
);
    import arlpp_pkg::*;

    localparam int     FB    = 16;
    localparam longint ONE   = longint'(1) << FB;
    localparam longint MAX32 = 64'sd2147483647;
    localparam longint MIN32 = -MAX32 - 1;

    // Packed so that position sits in the low half, as on m_tdata
    typedef struct packed {
        logic signed [31:0] velocity;
        logic signed [31:0] position;
    } plan_t;

    logic [23:0]        gain_high_r;
    logic [23:0]        gain_low_r;
    logic [23:0]        decay_r;
    logic [23:0]        sync_ratio_r;
    logic [30:0]        vel_limit_r;
    logic [30:0]        step_limit_r;
    logic [15:0]        sample_time_r;
    logic signed [31:0] held_position;
    logic signed [31:0] held_velocity;

    plan_t plan_q[$];
    plan_t want;
    plan_t got;
    plan_t fresh;
    int    fail_count = 0;

    function automatic longint clip32(input longint v);
        if (v > MAX32) return MAX32;
        if (v < MIN32) return MIN32;
        return v;
    endfunction

    // Work out the next planned position and velocity from the held state
    function automatic plan_t next_plan(input logic signed [31:0] req,
                                        input logic signed [31:0] fdb,
                                        input logic [30:0] delay);
        longint err, aerr, x, f, gain, vel, t, corr, hi, lo, pos;
        plan_t  p;
        err  = clip32(longint'(req) - longint'(fdb));
        aerr = (err < 0) ? -err : err;

        // gain schedule: low gain near zero error, drifting toward the high gain
        x    = clip32((longint'(decay_r) * aerr) >>> FB);
        f    = (longint'(1) << (2 * FB)) / (ONE + x);
        gain = longint'(gain_high_r)
             + (((longint'(gain_low_r) - longint'(gain_high_r)) * f) >>> FB);
        vel  = clip32((err * gain) >>> FB);

        // shrink the magnitude by the sync correction; may flip the sign
        t    = clip32((longint'(sync_ratio_r) * gain) >>> FB);
        corr = clip32((t * longint'(delay)) >>> FB);
        if (vel > 0) begin
            vel = clip32(vel - corr);
        end else if (vel < 0) begin
            vel = clip32(vel + corr);
        end

        // rate and magnitude clamp; upper bound applied last so it wins
        hi = longint'(held_velocity) + longint'(step_limit_r);
        if (hi > longint'(vel_limit_r)) hi = longint'(vel_limit_r);
        lo = longint'(held_velocity) - longint'(step_limit_r);
        if (lo < -longint'(vel_limit_r)) lo = -longint'(vel_limit_r);
        if (vel < lo) vel = lo;
        if (vel > hi) vel = hi;

        pos = clip32(longint'(held_position) + ((longint'(sample_time_r) * vel) >>> FB));
        p.position = pos[31:0];
        p.velocity = vel[31:0];
        return p;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            gain_high_r   = 24'd2116623;
            gain_low_r    = 24'd211662;
            decay_r       = 24'd819200;
            sync_ratio_r  = 24'd65536;
            vel_limit_r   = 31'd10202133;
            step_limit_r  = 31'd2116616;
            sample_time_r = 16'd655;
            held_position = '0;
            held_velocity = '0;
            plan_q.delete();
        end else begin
            // Track register writes; unmapped indexes are dropped
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_GAIN_HIGH:      gain_high_r   = cfg_data[23:0];
                    CFG_GAIN_LOW:       gain_low_r    = cfg_data[23:0];
                    CFG_DECAY_RATE:     decay_r       = cfg_data[23:0];
                    CFG_SYNC_RATIO:     sync_ratio_r  = cfg_data[23:0];
                    CFG_VEL_LIMIT:      vel_limit_r   = cfg_data[30:0];
                    CFG_VEL_STEP_LIMIT: step_limit_r  = cfg_data[30:0];
                    CFG_SAMPLE_TIME:    sample_time_r = cfg_data[15:0];
                    default: ;
                endcase
            end

            // Compare each result word with the oldest prediction
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (plan_q.size() == 0) begin
                    $display("%0t: result word with nothing expected, actual %h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = plan_q.pop_front();
                    if (got.position !== want.position) begin
                        $display("%0t: smoothed_position expected %h, actual %h",
                                 $time, want.position, got.position);
                        fail_count++;
                    end
                    if (got.velocity !== want.velocity) begin
                        $display("%0t: commanded_velocity expected %h, actual %h",
                                 $time, want.velocity, got.velocity);
                        fail_count++;
                    end
                end
            end

            // Predict the result of each accepted input word and advance the state
            if (s_tvalid && s_tready) begin
                fresh = next_plan(s_tdata[31:0], s_tdata[63:32], s_tdata[94:64]);
                plan_q.push_back(fresh);
                held_position = fresh.position;
                held_velocity = fresh.velocity;
            end
        end
        outstanding <= plan_q.size();
        mismatches  <= fail_count;
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the path planner testbench: clock, reset, stimulus, stalls and verdict.
// Depends on arlpp_pkg, the planner RTL and planner_checker.

module testbench;
    import arlpp_pkg::*;

    localparam logic [2:0] CFG_UNMAPPED = 3'd7;
    localparam int         QUIET_LIMIT  = 4000;

    localparam logic [31:0] GAIN_HIGH_RST  = 32'd2116623;
    localparam logic [31:0] GAIN_LOW_RST   = 32'd211662;
    localparam logic [31:0] DECAY_RST      = 32'd819200;
    localparam logic [31:0] SYNC_RATIO_RST = 32'd65536;
    localparam logic [31:0] VEL_LIMIT_RST  = 32'd10202133;
    localparam logic [31:0] STEP_LIMIT_RST = 32'd2116616;
    localparam logic [31:0] SAMPLE_RST     = 32'd655;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    wire         s_tready;
    logic [95:0] s_tdata   = '0;    // requested_position, actuator_feedback, sync_delay, pad
    wire         m_tvalid;
    logic        m_tready  = 1'b0;
    wire  [63:0] m_tdata;           // smoothed_position, commanded_velocity
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    int          mismatches;
    int          outstanding;
    int          quiet_cycles = 0;
    int          ready_hold   = 0;
    logic        m_stall_on   = 1'b0;
    bit          s_gaps_on    = 1'b0;
    logic [31:0] seen_position = '0;

    always #6 aclk = ~aclk;

    adaptive_rate_limited_path_planner dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    planner_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    function automatic logic [31:0] extreme_word();
        case ($urandom_range(0, 4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // Register value: extremes, reset-like values, or scaled random
    function automatic logic [31:0] pick_setting(input logic [31:0] reset_val,
                                                 input int width);
        logic [31:0] mask;
        mask = (32'd1 << width) - 32'd1;
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return mask;
            2:       return $urandom;
            3, 4:    return reset_val;
            5, 6:    return ($urandom >> $urandom_range(0, 31)) & mask;
            default: return ((reset_val << $urandom_range(0, 2)) >> $urandom_range(0, 2)) & mask;
        endcase
    endfunction

    // Receiver: random stalls, remember the latest planned position
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            seen_position <= m_tdata[31:0];
        end
        if (ready_hold > 0) begin
            m_tready   <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if (m_stall_on && $urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            ready_hold <= pick_gap() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: end the run when no channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic [31:0] req, input logic [31:0] fdb,
                             input logic [30:0] delay);
        int gap;
        gap = (s_gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, delay, fdb, req};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Mostly closed-loop samples with small errors, the rest noise, extremes and zero-error words
    task automatic send_random_word();
        logic [31:0] req, fdb, delta;
        logic [30:0] delay;
        int          mode;
        mode = $urandom_range(0, 99);
        if (mode < 55) begin
            fdb   = ($urandom_range(0, 1) == 1) ? seen_position : $urandom;
            delta = $urandom;
            delta = $signed(delta) >>> $urandom_range(6, 30);
            req   = fdb + delta;
            delay = ($urandom_range(0, 2) == 0) ? 31'd0 : 31'($urandom >> $urandom_range(10, 31));
        end else if (mode < 80) begin
            req   = $urandom;
            fdb   = $urandom;
            delay = 31'($urandom);
        end else if (mode < 90) begin
            req   = extreme_word();
            fdb   = extreme_word();
            delay = ($urandom_range(0, 1) == 1) ? 31'h7FFF_FFFF : 31'd0;
        end else begin
            req   = $urandom;
            fdb   = req;
            delay = 31'($urandom);
        end
        send_word(req, fdb, delay);
    endtask

    // Hold the sender until every expected result word is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_settings(input logic [31:0] gh, input logic [31:0] gl,
                                 input logic [31:0] dr, input logic [31:0] sr,
                                 input logic [31:0] vl, input logic [31:0] vsl,
                                 input logic [31:0] st);
        write_reg(CFG_UNMAPPED, $urandom);
        write_reg(CFG_GAIN_HIGH, gh);
        write_reg(CFG_GAIN_LOW, gl);
        write_reg(CFG_DECAY_RATE, dr);
        write_reg(CFG_SYNC_RATIO, sr);
        write_reg(CFG_VEL_LIMIT, vl);
        write_reg(CFG_VEL_STEP_LIMIT, vsl);
        write_reg(CFG_SAMPLE_TIME, st);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling();
        s_gaps_on  = ($urandom_range(0, 3) != 0);
        m_stall_on <= ($urandom_range(0, 3) != 0);
    endtask

    initial begin
        int i;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words at reset settings
        send_word(32'h0, 32'h0, 31'h0);
        send_word(32'h0001_0000, 32'h0, 31'h0);
        send_word(32'h7FFF_FFFF, 32'h8000_0000, 31'h0);
        send_word(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        // correction beyond the velocity flips its sign
        send_word(32'h0000_8000, 32'h0, 31'h7FFF_FFFF);
        send_word(32'hFFFF_8000, 32'h0, 31'h7FFF_FFFF);
        // zero error: no correction
        send_word(32'h1234_5678, 32'h1234_5678, 31'h0000_04D2);
        send_word(32'hFFFF_FFFF, 32'h0, 31'h1);
        send_word(32'h0, 32'hFFFF_FFFF, 31'h1);
        for (i = 1; i <= 7; i++) begin
            send_word(32'(i * 32'h2_0000), 32'(i * 32'h1_0000), 31'h100);
        end
        // drive into the step and magnitude limits both ways
        for (i = 0; i < 3; i++) send_word(32'h7FFF_FFFF, 32'h0, 31'h0);
        for (i = 0; i < 3; i++) send_word(32'h8000_0000, 32'h0, 31'h0);
        wait_drained();

        // Top extremes, gain_low above gain_high; masked upper bits
        set_idling();
        load_settings(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (i = 0; i < 40; i++) send_random_word();
        for (i = 0; i < 3; i++) send_word(32'h7FFF_FFFF, 32'h0, 31'h0);
        wait_drained();

        // Shrink the limits under a large held velocity so the bounds cross
        set_idling();
        load_settings(GAIN_HIGH_RST, GAIN_LOW_RST, DECAY_RST, SYNC_RATIO_RST,
                      32'h0001_0000, 32'h0000_0100, 32'h0);
        for (i = 0; i < 30; i++) send_random_word();
        wait_drained();

        // Gain schedule that falls as the error grows
        set_idling();
        load_settings(32'h0000_1000, 32'h0040_0000, DECAY_RST, SYNC_RATIO_RST,
                      VEL_LIMIT_RST, STEP_LIMIT_RST, SAMPLE_RST);
        send_word(32'h0, 32'h0, 31'h0);
        send_word(32'h0000_4000, 32'h0, 31'h0);
        send_word(32'h0100_0000, 32'h0, 31'h0);
        send_word(32'h0, 32'h0100_0000, 31'h10);
        for (i = 0; i < 40; i++) send_random_word();
        wait_drained();

        // Random settings phases, with an occasional full drain mid-phase
        repeat (10) begin
            set_idling();
            load_settings(pick_setting(GAIN_HIGH_RST, 24), pick_setting(GAIN_LOW_RST, 24),
                          pick_setting(DECAY_RST, 24), pick_setting(SYNC_RATIO_RST, 24),
                          pick_setting(VEL_LIMIT_RST, 31), pick_setting(STEP_LIMIT_RST, 31),
                          pick_setting(SAMPLE_RST, 16));
            for (i = 0; i < 120; i++) begin
                send_random_word();
                if ($urandom_range(0, 63) == 0) wait_drained();
            end
            wait_drained();
        end

        repeat (60) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/arlpp_pkg.sv
hw/rtl/arlpp_mul.sv
hw/rtl/arlpp_div.sv
hw/rtl/adaptive_rate_limited_path_planner.sv
tb/planner_checker.sv
tb/testbench.sv
